>>> rtl/delayed_message_timer_queue_assert.svh
// Assertion macros used by the timer queue top level.
`ifndef DELAYED_MESSAGE_TIMER_QUEUE_ASSERT_SVH
`define DELAYED_MESSAGE_TIMER_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DMTQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DMTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DMTQ_ASSERT(lbl, clk, rstn, prop, msg)
`define DMTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> rtl/dmtq_pkg.sv
// Shared widths, codes and controller/datapath signal groups of the timer queue.
package dmtq_pkg;

  localparam int PID_W   = 8;
  localparam int HND_W   = 32;
  localparam int DELAY_W = 24;
  localparam int DIV_W   = 11;

  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_TICK     = 1'b1;
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic ins_init;
    logic tick;
    logic rd_ins;
    logic rd_head;
    logic shift_wr;
    logic new_wr;
    logic take_pend;
    logic emit;
    logic emit_kind;
    logic emit_status;
    logic emit_last;
  } dmtq_cmd_t;

  typedef struct packed {
    logic cmd_tick;
    logic full;
    logic empty;
    logic slot_zero;
    logic rd_later;
    logic rd_due;
    logic div_done;
    logic out_free;
  } dmtq_sts_t;

endpackage

>>> rtl/dmtq_if.sv
// Request and response channel interfaces of the timer queue.
interface dmtq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [dmtq_pkg::PID_W-1:0]   sender_pid;
  logic [dmtq_pkg::PID_W-1:0]   dest_pid;
  logic [dmtq_pkg::HND_W-1:0]   message_handle;
  logic [dmtq_pkg::DELAY_W-1:0] delay_ms;

  modport source (output valid, cmd, sender_pid, dest_pid, message_handle, delay_ms,
                  input ready);
  modport sink (input valid, cmd, sender_pid, dest_pid, message_handle, delay_ms,
                output ready);
endinterface

interface dmtq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic                      status;
  logic [dmtq_pkg::PID_W-1:0] out_sender_pid;
  logic [dmtq_pkg::PID_W-1:0] out_dest_pid;
  logic [dmtq_pkg::HND_W-1:0] out_handle;
  logic                      last;

  modport source (output valid, kind, status, out_sender_pid, out_dest_pid, out_handle,
                  last, input ready);
  modport sink (input valid, kind, status, out_sender_pid, out_dest_pid, out_handle,
                last, output ready);
endinterface

>>> rtl/delayed_message_timer_queue.sv
// Top level of the delayed message timer queue.
// The block keeps up to QUEUE_DEPTH messages sorted by expiry, one transaction at a time.
// A schedule transaction first waits for the bit-serial divider that divides the delay by
// the configured divisor; the insertion walk then does one read and one write of the entry
// memory for every queued entry with a later expiry that it moves. A tick transaction
// releases every due entry, reading each head entry through the registered memory read.
// A result that cannot leave the output register holds the block for as long as the
// receiver stalls. No clearing pass is needed after reset, and a result waiting in the
// output register does not stop the next transaction being accepted.
`include "delayed_message_timer_queue_assert.svh"
module delayed_message_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dmtq_req_if.sink                   req_i,
  dmtq_rsp_if.source                 rsp_o,
  input  logic                       cfg_we_i,
  input  logic [dmtq_pkg::DIV_W-1:0] cfg_wdata_i
);
  import dmtq_pkg::*;

  dmtq_cmd_t cmd;
  dmtq_sts_t sts;

  dmtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dmtq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_cmd_i            (req_i.cmd),
    .in_sender_pid_i     (req_i.sender_pid),
    .in_dest_pid_i       (req_i.dest_pid),
    .in_message_handle_i (req_i.message_handle),
    .in_delay_ms_i       (req_i.delay_ms),
    .out_ready_i         (rsp_o.ready),
    .out_valid_o         (rsp_o.valid),
    .out_kind_o          (rsp_o.kind),
    .out_status_o        (rsp_o.status),
    .out_sender_pid_o    (rsp_o.out_sender_pid),
    .out_dest_pid_o      (rsp_o.out_dest_pid),
    .out_handle_o        (rsp_o.out_handle),
    .out_last_o          (rsp_o.last)
  );

  `DMTQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_i.valid && req_i.ready,
                    !req_i.ready, "accepted a transaction while one is in progress")
  `DMTQ_ASSERT(a_emit_needs_room, clk_i, rst_ni, !cmd.emit || sts.out_free,
               "result loaded over an untaken result")
  `DMTQ_ASSERT(a_insert_not_full, clk_i, rst_ni, !cmd.new_wr || !sts.full,
               "entry inserted into a full queue")
  `DMTQ_ASSERT(a_pop_not_empty, clk_i, rst_ni, !cmd.take_pend || !sts.empty,
               "entry released from an empty queue")

endmodule

>>> rtl/dmtq_divider.sv
// Restoring divider, one quotient bit per cycle, for the delay scaling.
module dmtq_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dmtq_pkg::DELAY_W-1:0]  dividend_i,
  input  logic [dmtq_pkg::DIV_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [dmtq_pkg::DELAY_W-1:0]  quotient_o
);
  import dmtq_pkg::*;

  localparam int CNT_W = $clog2(DELAY_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DELAY_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W:0]   rem_shift;

  always_comb begin
    rem_shift = {rem_q, quo_q[DELAY_W-1]};
    if (rem_shift >= {1'b0, div_q}) begin
      rem_d = DIV_W'(rem_shift - {1'b0, div_q});
      quo_d = {quo_q[DELAY_W-2:0], 1'b1};
    end else begin
      rem_d = rem_shift[DIV_W-1:0];
      quo_d = {quo_q[DELAY_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DELAY_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // A zero divisor divides as one.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= (divisor_i == '0) ? DIV_W'(1) : divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/dmtq_datapath.sv
// Datapath of the timer queue: entry memory, time counter, divider and output register.
module dmtq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dmtq_pkg::dmtq_cmd_t          cmd_i,
  output dmtq_pkg::dmtq_sts_t          sts_o,
  input  logic                         cfg_we_i,
  input  logic [dmtq_pkg::DIV_W-1:0]   cfg_wdata_i,
  input  logic                         in_cmd_i,
  input  logic [dmtq_pkg::PID_W-1:0]   in_sender_pid_i,
  input  logic [dmtq_pkg::PID_W-1:0]   in_dest_pid_i,
  input  logic [dmtq_pkg::HND_W-1:0]   in_message_handle_i,
  input  logic [dmtq_pkg::DELAY_W-1:0] in_delay_ms_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic                         out_kind_o,
  output logic                         out_status_o,
  output logic [dmtq_pkg::PID_W-1:0]   out_sender_pid_o,
  output logic [dmtq_pkg::PID_W-1:0]   out_dest_pid_o,
  output logic [dmtq_pkg::HND_W-1:0]   out_handle_o,
  output logic                         out_last_o
);
  import dmtq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;

  typedef struct packed {
    logic [TIME_BITS-1:0] expiry;
    logic [PID_W-1:0]     snd;
    logic [PID_W-1:0]     rcv;
    logic [HND_W-1:0]     hnd;
  } entry_t;

  // Entries live in a circular buffer; slot numbers are relative to the head.
  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(QUEUE_DEPTH)) s = s - (IDX_W+1)'(QUEUE_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q, pend_q, wr_data, new_entry;

  logic                 cmd_q;
  logic [PID_W-1:0]     snd_q, rcv_q;
  logic [HND_W-1:0]     hnd_q;
  logic [DELAY_W-1:0]   delay_q;
  logic [TIME_BITS-1:0] expiry_q, time_q;
  logic [IDX_W-1:0]     head_q, slot_q, wr_addr, rd_addr;
  logic [CNT_W-1:0]     count_q;
  logic [DIV_W-1:0]     divisor_q;
  logic                 mem_we, mem_re;
  logic                 div_done;
  logic [DELAY_W-1:0]   quotient;
  logic [SUM_W-1:0]     expiry_sum;
  logic                 out_valid_q, out_free;
  logic                 out_kind_q, out_status_q, out_last_q;
  logic [PID_W-1:0]     out_snd_q, out_rcv_q;
  logic [HND_W-1:0]     out_hnd_q;

  dmtq_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (delay_q),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign expiry_sum = SUM_W'(time_q) + SUM_W'(quotient);
  assign new_entry  = '{expiry: expiry_sum[TIME_BITS-1:0], snd: snd_q, rcv: rcv_q, hnd: hnd_q};

  always_comb begin
    mem_we  = cmd_i.shift_wr | cmd_i.new_wr;
    mem_re  = cmd_i.rd_ins | cmd_i.rd_head;
    wr_addr = wrap_add(head_q, slot_q);
    rd_addr = wrap_add(head_q, cmd_i.rd_head ? '0 : IDX_W'(slot_q - 1'b1));
    if (cmd_i.shift_wr) begin
      wr_data = rd_q;
    end else begin
      wr_data        = new_entry;
      wr_data.expiry = expiry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= in_cmd_i;
      snd_q   <= in_sender_pid_i;
      rcv_q   <= in_dest_pid_i;
      hnd_q   <= in_message_handle_i;
      delay_q <= in_delay_ms_i;
    end
    if (div_done) expiry_q <= expiry_sum[TIME_BITS-1:0];
    if (cmd_i.take_pend) pend_q <= rd_q;
    if (cmd_i.ins_init) begin
      slot_q <= count_q[IDX_W-1:0];
    end else if (cmd_i.shift_wr) begin
      slot_q <= slot_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q    <= '0;
      head_q    <= '0;
      count_q   <= '0;
      divisor_q <= DIV_W'(1);
    end else begin
      if (cfg_we_i) divisor_q <= cfg_wdata_i;
      if (cmd_i.tick) time_q <= time_q + 1'b1;
      if (cmd_i.new_wr) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.take_pend) begin
        count_q <= count_q - 1'b1;
        head_q  <= wrap_add(head_q, IDX_W'(1));
      end
    end
  end

  // Output register: a result may wait here while the next transaction is accepted.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q   <= cmd_i.emit_kind;
      out_status_q <= cmd_i.emit_status;
      out_last_q   <= cmd_i.emit_last;
      if (cmd_i.emit_kind == KIND_RELEASE) begin
        out_snd_q <= pend_q.snd;
        out_rcv_q <= pend_q.rcv;
        out_hnd_q <= pend_q.hnd;
      end else begin
        out_snd_q <= '0;
        out_rcv_q <= '0;
        out_hnd_q <= '0;
      end
    end
  end

  always_comb begin
    sts_o.cmd_tick  = (cmd_q == CMD_TICK);
    sts_o.full      = (count_q == CNT_W'(QUEUE_DEPTH));
    sts_o.empty     = (count_q == '0);
    sts_o.slot_zero = (slot_q == '0);
    sts_o.rd_later  = (rd_q.expiry > expiry_q);
    sts_o.rd_due    = (rd_q.expiry <= time_q);
    sts_o.div_done  = div_done;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = out_kind_q;
  assign out_status_o     = out_status_q;
  assign out_sender_pid_o = out_snd_q;
  assign out_dest_pid_o   = out_rcv_q;
  assign out_handle_o     = out_hnd_q;
  assign out_last_o       = out_last_q;

endmodule

>>> rtl/dmtq_ctrl.sv
// Controller state machine of the timer queue.
module dmtq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dmtq_pkg::dmtq_sts_t sts_i,
  output dmtq_pkg::dmtq_cmd_t cmd_o
);
  import dmtq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ACK_FULL,
    ST_DIV,
    ST_INS_RD,
    ST_INS_CMP,
    ST_ACK,
    ST_REL_NEXT,
    ST_REL_CHK
  } state_e;

  state_e state_q, state_d;
  logic   have_pend_q, have_pend_d;

  always_comb begin
    state_d     = state_q;
    have_pend_d = have_pend_q;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.cmd_tick) begin
          cmd_o.tick  = 1'b1;
          have_pend_d = 1'b0;
          state_d     = ST_REL_NEXT;
        end else if (sts_i.full) begin
          state_d = ST_ACK_FULL;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.ins_init  = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_ACK_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_kind   = KIND_ACK;
          cmd_o.emit_status = STATUS_FULL;
          cmd_o.emit_last   = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_INS_RD;
      end
      // Walk down from the tail, moving later entries up one slot.
      ST_INS_RD: begin
        if (sts_i.slot_zero) begin
          cmd_o.new_wr = 1'b1;
          state_d      = ST_ACK;
        end else begin
          cmd_o.rd_ins = 1'b1;
          state_d      = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts_i.rd_later) begin
          cmd_o.shift_wr = 1'b1;
          state_d        = ST_INS_RD;
        end else begin
          cmd_o.new_wr = 1'b1;
          state_d      = ST_ACK;
        end
      end
      ST_ACK: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_kind   = KIND_ACK;
          cmd_o.emit_status = STATUS_OK;
          cmd_o.emit_last   = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      // A popped entry is held back until the next head shows whether it is the last.
      ST_REL_NEXT: begin
        if (sts_i.empty) begin
          if (!have_pend_q) begin
            state_d = ST_IDLE;
          end else if (sts_i.out_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_kind   = KIND_RELEASE;
            cmd_o.emit_status = STATUS_OK;
            cmd_o.emit_last   = 1'b1;
            have_pend_d       = 1'b0;
            state_d           = ST_IDLE;
          end
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = ST_REL_CHK;
        end
      end
      ST_REL_CHK: begin
        if (!have_pend_q || sts_i.out_free) begin
          if (have_pend_q) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_kind   = KIND_RELEASE;
            cmd_o.emit_status = STATUS_OK;
            cmd_o.emit_last   = !sts_i.rd_due;
          end
          if (sts_i.rd_due) begin
            cmd_o.take_pend = 1'b1;
            have_pend_d     = 1'b1;
            state_d         = ST_REL_NEXT;
          end else begin
            have_pend_d = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_pend_q <= have_pend_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

>>> bench/delayed_message_timer_queue_tb.sv
// Self-checking testbench for the delayed message timer queue, with a shadow queue model.
`timescale 1ns / 1ps
module delayed_message_timer_queue_tb;
  import dmtq_pkg::*;

  localparam int QDEPTH        = 16;
  localparam int SETTLE_CYCLES = 150;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 4000;

  typedef struct packed {
    logic               cmd;
    logic [PID_W-1:0]   sender;
    logic [PID_W-1:0]   receiver;
    logic [HND_W-1:0]   handle;
    logic [DELAY_W-1:0] delay;
  } timer_req_t;

  typedef struct packed {
    logic             kind;
    logic             status;
    logic [PID_W-1:0] sender;
    logic [PID_W-1:0] receiver;
    logic [HND_W-1:0] handle;
    logic             last;
  } timer_rsp_t;

  logic clk_i;
  logic rst_ni = 1'b1;
  logic cfg_we_i = 1'b0;
  logic [DIV_W-1:0] cfg_wdata_i = '0;

  dmtq_req_if req_bus();
  dmtq_rsp_if rsp_bus();

  delayed_message_timer_queue #(
    .QUEUE_DEPTH(QDEPTH),
    .TIME_BITS  (32)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow copy of the block's state and register.
  logic [31:0]      sh_time = '0;
  int               sh_count = 0;
  logic [31:0]      sh_expiry   [QDEPTH];
  logic [PID_W-1:0] sh_sender   [QDEPTH];
  logic [PID_W-1:0] sh_receiver [QDEPTH];
  logic [HND_W-1:0] sh_handle   [QDEPTH];
  logic [DIV_W-1:0] sh_divisor;

  timer_req_t outgoing_req[$];
  timer_rsp_t awaited_rsp[$];
  timer_req_t in_flight;
  timer_req_t next_req;
  timer_rsp_t got_rsp;
  timer_rsp_t want_rsp;

  int burst_left;
  int gap_left;
  int hold_requests;
  int holds_served;
  int hold_left;
  int stall_mode;
  int mode_left;
  int idle_cycles;
  int mismatches;
  int ticks_sent;
  int acks_seen;
  int full_seen;
  int releases_seen;
  int mid_divisor;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  function automatic void apply_to_shadow_queue(input timer_req_t r);
    logic [DIV_W-1:0]   eff;
    logic [DELAY_W-1:0] quot;
    logic [31:0]        expiry;
    timer_rsp_t         res;
    int                 pos;
    int                 due;
    res = '0;
    if (r.cmd == CMD_SCHEDULE) begin
      res.kind = KIND_ACK;
      res.last = 1'b1;
      if (sh_count >= QDEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        res.status = STATUS_OK;
        eff = (sh_divisor == '0) ? DIV_W'(1) : sh_divisor;
        quot = r.delay / eff;
        expiry = sh_time + {8'b0, quot};
        pos = 0;
        // Equal expiries go behind the ones already queued.
        while (pos < sh_count && sh_expiry[pos] <= expiry) pos++;
        for (int i = sh_count; i > pos; i--) begin
          sh_expiry[i]   = sh_expiry[i-1];
          sh_sender[i]   = sh_sender[i-1];
          sh_receiver[i] = sh_receiver[i-1];
          sh_handle[i]   = sh_handle[i-1];
        end
        sh_expiry[pos]   = expiry;
        sh_sender[pos]   = r.sender;
        sh_receiver[pos] = r.receiver;
        sh_handle[pos]   = r.handle;
        sh_count++;
      end
      awaited_rsp.push_back(res);
    end else begin
      sh_time = sh_time + 32'd1;
      due = 0;
      while (due < sh_count && sh_expiry[due] <= sh_time) due++;
      for (int i = 0; i < due; i++) begin
        res.kind     = KIND_RELEASE;
        res.status   = STATUS_OK;
        res.sender   = sh_sender[i];
        res.receiver = sh_receiver[i];
        res.handle   = sh_handle[i];
        res.last     = (i == due - 1);
        awaited_rsp.push_back(res);
      end
      for (int i = 0; i < sh_count - due; i++) begin
        sh_expiry[i]   = sh_expiry[i+due];
        sh_sender[i]   = sh_sender[i+due];
        sh_receiver[i] = sh_receiver[i+due];
        sh_handle[i]   = sh_handle[i+due];
      end
      sh_count = sh_count - due;
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid          <= 1'b0;
      req_bus.cmd            <= CMD_SCHEDULE;
      req_bus.sender_pid     <= '0;
      req_bus.dest_pid       <= '0;
      req_bus.message_handle <= '0;
      req_bus.delay_ms       <= '0;
      burst_left             <= 0;
      gap_left               <= 0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (req_bus.valid) begin
        apply_to_shadow_queue(in_flight);
        if (in_flight.cmd == CMD_TICK) ticks_sent++;
      end
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        req_bus.valid <= 1'b0;
      end else if (outgoing_req.size() != 0) begin
        next_req = outgoing_req.pop_front();
        in_flight              <= next_req;
        req_bus.valid          <= 1'b1;
        req_bus.cmd            <= next_req.cmd;
        req_bus.sender_pid     <= next_req.sender;
        req_bus.dest_pid       <= next_req.receiver;
        req_bus.message_handle <= next_req.handle;
        req_bus.delay_ms       <= next_req.delay;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 10);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus requested long hold-offs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      holds_served  <= 0;
      hold_left     <= 0;
      stall_mode    <= 0;
      mode_left     <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= holds_served + 1;
      hold_left     <= LONG_HOLD;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: begin
          rsp_bus.ready <= 1'b1;
        end
        1: begin
          rsp_bus.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          rsp_bus.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          rsp_bus.ready <= ($urandom_range(0, 7) != 0);
        end
      endcase
    end
  end

  // Monitor: each result transaction is checked against the oldest awaited one.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got_rsp.kind     = rsp_bus.kind;
      got_rsp.status   = rsp_bus.status;
      got_rsp.sender   = rsp_bus.out_sender_pid;
      got_rsp.receiver = rsp_bus.out_dest_pid;
      got_rsp.handle   = rsp_bus.out_handle;
      got_rsp.last     = rsp_bus.last;
      if (got_rsp.kind == KIND_RELEASE) releases_seen++;
      else if (got_rsp.status == STATUS_FULL) full_seen++;
      else acks_seen++;
      if (awaited_rsp.size() == 0) begin
        note_mismatch("result with nothing awaited", got_rsp.handle, '0);
      end else begin
        want_rsp = awaited_rsp.pop_front();
        if (got_rsp.kind != want_rsp.kind)
          note_mismatch("kind", 32'(got_rsp.kind), 32'(want_rsp.kind));
        if (got_rsp.status != want_rsp.status)
          note_mismatch("status", 32'(got_rsp.status), 32'(want_rsp.status));
        if (got_rsp.sender != want_rsp.sender)
          note_mismatch("out_sender_pid", 32'(got_rsp.sender), 32'(want_rsp.sender));
        if (got_rsp.receiver != want_rsp.receiver)
          note_mismatch("out_dest_pid", 32'(got_rsp.receiver), 32'(want_rsp.receiver));
        if (got_rsp.handle != want_rsp.handle)
          note_mismatch("out_handle", got_rsp.handle, want_rsp.handle);
        if (got_rsp.last != want_rsp.last)
          note_mismatch("last", 32'(got_rsp.last), 32'(want_rsp.last));
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, awaited_rsp.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic push_schedule(input logic [PID_W-1:0] snd, input logic [PID_W-1:0] rcv,
                               input logic [HND_W-1:0] hnd, input logic [DELAY_W-1:0] dly);
    timer_req_t r;
    r.cmd      = CMD_SCHEDULE;
    r.sender   = snd;
    r.receiver = rcv;
    r.handle   = hnd;
    r.delay    = dly;
    outgoing_req.push_back(r);
  endtask

  task automatic push_tick();
    timer_req_t r;
    r.cmd      = CMD_TICK;
    r.sender   = PID_W'($urandom);
    r.receiver = PID_W'($urandom);
    r.handle   = HND_W'($urandom);
    r.delay    = DELAY_W'($urandom);
    outgoing_req.push_back(r);
  endtask

  // Mostly short delays so that entries come due; now and then a full-range one.
  task automatic random_phase(input int count, input int span);
    logic [DELAY_W-1:0] dly;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 52) begin
        if ($urandom_range(0, 31) == 0) dly = DELAY_W'($urandom);
        else dly = DELAY_W'($urandom_range(0, span));
        push_schedule(PID_W'($urandom), PID_W'($urandom), HND_W'($urandom), dly);
      end else begin
        push_tick();
      end
    end
  endtask

  task automatic wait_for_idle();
    while (outgoing_req.size() != 0 || req_bus.valid || awaited_rsp.size() != 0)
      @(posedge clk_i);
    // A tick that releases nothing leaves no result to wait for.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_divisor(input logic [DIV_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sh_divisor = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    sh_divisor    = DIV_W'(1);
    hold_requests = 0;
    mid_divisor   = $urandom_range(2, 200);
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Directed: fill the queue with one expiry, overflow it, then release all sixteen at once.
    for (int i = 0; i < QDEPTH; i++)
      push_schedule(PID_W'(i), PID_W'(255 - i), HND_W'($urandom), 24'd3);
    push_schedule(8'h5a, 8'ha5, 32'hdead_beef, 24'd0);
    push_tick();
    push_tick();
    push_tick();
    // Longest delay stays queued; the two ties then go in front of it, in arrival order.
    push_schedule(8'hff, 8'h00, 32'h1234_5678, 24'hff_ffff);
    push_schedule(8'h00, 8'h00, 32'h0000_0000, 24'd0);
    push_schedule(8'hff, 8'hff, 32'hffff_ffff, 24'd0);
    push_tick();
    push_tick();
    wait_for_idle();

    // Zero divisor behaves as one.
    write_divisor(DIV_W'(0));
    random_phase(30, 6);
    wait_for_idle();

    write_divisor(DIV_W'(2047));
    random_phase(30, 2047 * 6);
    wait_for_idle();

    write_divisor(DIV_W'(1024));
    random_phase(30, 1024 * 6);
    wait_for_idle();

    write_divisor(DIV_W'(mid_divisor));
    random_phase(35, mid_divisor * 6);
    wait_for_idle();

    // The receiver holds off while the sender keeps offering, so the block backs up.
    write_divisor(DIV_W'(1));
    hold_requests++;
    random_phase(30, 6);
    wait_for_idle();

    $display("covered %0d schedules accepted, %0d dropped as full, %0d ticks, %0d releases",
             acks_seen, full_seen, ticks_sent, releases_seen);
    $display("divisors used: reset value, 0, 2047, 1024, %0d and 1, with one long output hold",
             mid_divisor);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
